>>> rtl/ivr_pkg.sv
// Shared types and constants for the isokinetic velocity rescaler.
package ivr_pkg;

  // Operation codes carried with each request.
  typedef enum logic [1:0] {
    OP_ACC  = 2'd0,
    OP_FIN  = 2'd1,
    OP_RSC  = 2'd2,
    OP_NONE = 2'd3
  } ivr_op_e;

  // Reset values of the programmable and held state.
  localparam logic [31:0] HALF_DT_RESET = 32'h0080_0000;
  localparam logic [31:0] SCALE_ONE     = 32'h1000_0000;

  // ln 2 in Q.32 and the exponent offset of 35 * ln 2.
  localparam logic [31:0] LN2_Q32      = 32'd2977044472;
  localparam logic [36:0] Z_OFFSET     = 37'd104196556520;
  // Cap on the exponent magnitude (24.0) and the upper exponent limit (3.0).
  localparam logic [37:0] X_CAP        = 38'd24 << 32;
  localparam logic [37:0] Y_HIGH       = 38'd3 << 32;
  localparam logic [5:0]  SHIFT_BASE   = 6'd39;
  localparam logic [3:0]  TAYLOR_TERMS = 4'd14;
  localparam logic [2:0]  RED_TOP      = 3'd5;

  // Widths of the shared units.
  localparam int unsigned MUL_W   = 34;
  localparam int unsigned DVD_W   = 96;
  localparam int unsigned DVS_W   = 58;
  localparam int unsigned QUOT_W  = 38;
  localparam int unsigned STEP_W  = 7;

  // Control word handed to the divider.
  typedef struct packed {
    logic              start;
    logic              cap;
    logic [STEP_W-1:0] steps;
  } ivr_div_ctl_t;

endpackage

>>> rtl/ivr_mul.sv
// Shared signed multiplier with a registered product.
module ivr_mul (
  input  logic                               clk_i,
  input  logic signed [ivr_pkg::MUL_W-1:0]   a_i,
  input  logic signed [ivr_pkg::MUL_W-1:0]   b_i,
  output logic signed [2*ivr_pkg::MUL_W-1:0] p_o
);
  import ivr_pkg::*;

  logic signed [2*MUL_W-1:0] p_q;

  // One product per cycle, registered before any use.
  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

>>> rtl/ivr_div.sv
// Restoring divider that yields one quotient bit per cycle, with an optional cap.
module ivr_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ivr_pkg::ivr_div_ctl_t        ctl_i,
  input  logic [ivr_pkg::DVD_W-1:0]    dividend_i,
  input  logic [ivr_pkg::DVS_W-1:0]    divisor_i,
  output logic                         done_o,
  output logic [ivr_pkg::QUOT_W-1:0]   quot_o
);
  import ivr_pkg::*;

  logic [DVS_W-1:0]  rem_q;
  logic [DVD_W-1:0]  num_q;
  logic [DVS_W-1:0]  dvs_q;
  logic [QUOT_W-1:0] quo_q;
  logic [STEP_W-1:0] cnt_q;
  logic              cap_q;
  logic              done_q;

  logic [DVS_W:0]    rem_shift;
  logic              ge;
  logic [DVS_W:0]    rem_sub;
  logic [QUOT_W-1:0] quo_shift;
  logic [QUOT_W-1:0] quo_d;

  // One restoring step: bring in the next dividend bit and try a subtract.
  always_comb begin
    rem_shift = {rem_q, num_q[DVD_W-1]};
    ge        = rem_shift >= {1'b0, dvs_q};
    rem_sub   = rem_shift - {1'b0, dvs_q};
    quo_shift = {quo_q[QUOT_W-2:0], ge};
    if (cap_q && (quo_shift > X_CAP)) begin
      quo_d = X_CAP;
    end else begin
      quo_d = quo_shift;
    end
  end

  // Step counter and the working registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
      rem_q  <= '0;
      num_q  <= '0;
      dvs_q  <= '0;
      quo_q  <= '0;
      cap_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        cnt_q <= ctl_i.steps;
        cap_q <= ctl_i.cap;
        rem_q <= '0;
        quo_q <= '0;
        num_q <= dividend_i;
        dvs_q <= divisor_i;
      end else if (cnt_q != '0) begin
        rem_q <= ge ? rem_sub[DVS_W-1:0] : rem_shift[DVS_W-1:0];
        quo_q <= quo_d;
        num_q <= {num_q[DVD_W-2:0], 1'b0};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == STEP_W'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

>>> rtl/isokinetic_velocity_rescaler_top.sv
// Top level of the isokinetic velocity rescaler: sequencer, state and result register.
// An accumulate request (opcode 0) or a rescale request (opcode 2) runs its three
// components through the one shared multiplier, each in a multiply state and then
// an add or rounding state. A finish request (opcode 1) runs a 96-step restoring
// division, a six-step reduction by ln 2, and fourteen Taylor terms, every term
// needing one multiply and a 33-step division on the same divider; when the
// exponent saturates the scale at once, it ends after the division. Opcode 3 is
// accepted and gives no result. The input is stalled while a request is in work;
// a finished result sits in an output register, so the next request can be taken
// while that result waits to be read. A result that is still waiting holds the
// sequencer in its last state.
module isokinetic_velocity_rescaler_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] vel_x_i,
  input  logic [31:0] vel_y_i,
  input  logic [31:0] vel_z_i,
  input  logic [31:0] force_x_i,
  input  logic [31:0] force_y_i,
  input  logic [31:0] force_z_i,
  input  logic [47:0] kinetic_energy_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] scale_factor_o,
  output logic [31:0] out_vel_x_o,
  output logic [31:0] out_vel_y_o,
  output logic [31:0] out_vel_z_o,
  output logic        saturated_o
);
  import ivr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_ACC_MUL, S_ACC_ADD, S_RSC_MUL, S_RSC_RND,
    S_FIN_MLO, S_FIN_MHI, S_FIN_COMB, S_FIN_DWAIT, S_FIN_CHK, S_FIN_RED,
    S_EXP_MUL, S_EXP_DST, S_EXP_DWAIT, S_EXP_FIN, S_DONE
  } state_e;

  state_e             state_q;
  logic [31:0]        half_dt_q;
  logic signed [63:0] power_q;
  logic [31:0]        scale_q;
  logic [31:0]        vel_q [3];
  logic [31:0]        frc_q [3];
  logic [47:0]        ke_q;
  logic [1:0]         idx_q;
  logic               flag_q;
  logic [31:0]        res_q [3];
  logic [63:0]        plo_q;
  logic               neg_q;
  logic [36:0]        z_q;
  logic [5:0]         n_q;
  logic [2:0]         red_q;
  logic [32:0]        term_q;
  logic [33:0]        sum_q;
  logic [3:0]         k_q;

  logic               out_valid_q;
  logic [31:0]        out_scale_q;
  logic [31:0]        out_vel_q [3];
  logic               out_sat_q;

  logic signed [MUL_W-1:0]   mul_a;
  logic signed [MUL_W-1:0]   mul_b;
  logic signed [2*MUL_W-1:0] mul_p;
  ivr_div_ctl_t              div_ctl;
  logic [DVD_W-1:0]          div_num;
  logic [DVS_W-1:0]          div_dvs;
  logic                      div_done;
  logic [QUOT_W-1:0]         div_quot;

  logic               in_acc;
  logic               out_free;
  logic [63:0]        mag;
  logic signed [64:0] acc_sum;
  logic [63:0]        rsc_p;
  logic [63:0]        rsc_m;
  logic [35:0]        rsc_r;
  logic [95:0]        wide_prod;
  logic [36:0]        red_cmp;
  logic [5:0]         shamt;
  logic [40:0]        round_sum;
  logic [40:0]        exp_res;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign mag      = power_q[63] ? (64'd0 - 64'(power_q)) : 64'(power_q);

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (state_q)
      S_ACC_MUL: begin
        mul_a = MUL_W'(signed'(vel_q[idx_q]));
        mul_b = MUL_W'(signed'(frc_q[idx_q]));
      end
      S_RSC_MUL: begin
        mul_a = MUL_W'(signed'(vel_q[idx_q]));
        mul_b = signed'({2'b00, scale_q});
      end
      S_FIN_MLO: begin
        mul_a = signed'({2'b00, mag[31:0]});
        mul_b = signed'({2'b00, half_dt_q});
      end
      S_FIN_MHI: begin
        mul_a = signed'({2'b00, mag[63:32]});
        mul_b = signed'({2'b00, half_dt_q});
      end
      S_EXP_MUL: begin
        // After the reduction the low word of z is the remainder below ln 2.
        mul_a = signed'({1'b0, term_q});
        mul_b = signed'({2'b00, z_q[31:0]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  ivr_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // Divider requests: the main exponent quotient and each Taylor term divide.
  always_comb begin
    div_ctl = '0;
    div_num = '0;
    div_dvs = '0;
    unique case (state_q)
      S_FIN_COMB: begin
        div_ctl.start = 1'b1;
        div_ctl.cap   = 1'b1;
        div_ctl.steps = STEP_W'(DVD_W);
        div_num       = wide_prod;
        div_dvs       = DVS_W'(({10'd0, ke_q} + 58'd1) << 9);
      end
      S_EXP_DST: begin
        div_ctl.start = 1'b1;
        div_ctl.steps = STEP_W'(33);
        div_num       = {mul_p[64:32], 63'd0};
        div_dvs       = DVS_W'(k_q);
      end
      default: begin
        div_ctl = '0;
      end
    endcase
  end

  ivr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (div_ctl),
    .dividend_i (div_num),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Datapath helpers around the multiplier product.
  always_comb begin
    acc_sum   = {power_q[63], power_q} + 65'(mul_p[63:0]) + {mul_p[63], 64'd0};
    wide_prod = {32'd0, plo_q} + {mul_p[63:0], 32'd0};
    rsc_p     = mul_p[63:0];
    rsc_m     = rsc_p[63] ? (64'd0 - rsc_p) : rsc_p;
    rsc_r     = 36'((rsc_m + 64'd134217728) >> 28);
    red_cmp   = 37'(LN2_Q32) << red_q;
    shamt     = SHIFT_BASE - n_q;
    round_sum = {7'd0, sum_q} + ((shamt == 6'd0) ? 41'd0 : (41'd1 << (shamt - 6'd1)));
    exp_res   = round_sum >> shamt;
  end

  // Sequencer, thermostat state and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      half_dt_q   <= HALF_DT_RESET;
      power_q     <= '0;
      scale_q     <= SCALE_ONE;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      flag_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        half_dt_q <= cfg_wdata_i;
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            vel_q[0] <= vel_x_i;
            vel_q[1] <= vel_y_i;
            vel_q[2] <= vel_z_i;
            frc_q[0] <= force_x_i;
            frc_q[1] <= force_y_i;
            frc_q[2] <= force_z_i;
            ke_q     <= kinetic_energy_i;
            idx_q    <= '0;
            flag_q   <= 1'b0;
            res_q[0] <= '0;
            res_q[1] <= '0;
            res_q[2] <= '0;
            unique case (ivr_op_e'(opcode_i))
              OP_ACC:  state_q <= S_ACC_MUL;
              OP_FIN:  state_q <= S_FIN_MLO;
              OP_RSC:  state_q <= S_RSC_MUL;
              OP_NONE: state_q <= S_IDLE;
            endcase
          end
        end
        S_ACC_MUL: state_q <= S_ACC_ADD;
        S_ACC_ADD: begin
          // Saturating add into the signed 64-bit power sum.
          if (acc_sum[64] != acc_sum[63]) begin
            flag_q  <= 1'b1;
            power_q <= acc_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
          end else begin
            power_q <= acc_sum[63:0];
          end
          idx_q   <= idx_q + 2'd1;
          state_q <= (idx_q == 2'd2) ? S_DONE : S_ACC_MUL;
        end
        S_RSC_MUL: state_q <= S_RSC_RND;
        S_RSC_RND: begin
          // Round half away from zero, then clamp to the signed 32-bit range.
          if (!rsc_p[63] && (rsc_r > 36'h0_7FFF_FFFF)) begin
            flag_q       <= 1'b1;
            res_q[idx_q] <= 32'h7FFF_FFFF;
          end else if (rsc_p[63] && (rsc_r > 36'h0_8000_0000)) begin
            flag_q       <= 1'b1;
            res_q[idx_q] <= 32'h8000_0000;
          end else if (rsc_p[63]) begin
            res_q[idx_q] <= 32'd0 - rsc_r[31:0];
          end else begin
            res_q[idx_q] <= rsc_r[31:0];
          end
          idx_q   <= idx_q + 2'd1;
          state_q <= (idx_q == 2'd2) ? S_DONE : S_RSC_MUL;
        end
        S_FIN_MLO: begin
          neg_q   <= power_q[63];
          state_q <= S_FIN_MHI;
        end
        S_FIN_MHI: begin
          plo_q   <= mul_p[63:0];
          state_q <= S_FIN_COMB;
        end
        S_FIN_COMB: state_q <= S_FIN_DWAIT;
        S_FIN_DWAIT: begin
          if (div_done) begin
            state_q <= S_FIN_CHK;
          end
        end
        S_FIN_CHK: begin
          // An exponent above 3.0 saturates the scale at once.
          if (neg_q && (div_quot > Y_HIGH)) begin
            flag_q  <= 1'b1;
            scale_q <= 32'hFFFF_FFFF;
            power_q <= '0;
            state_q <= S_DONE;
          end else begin
            z_q     <= neg_q ? (Z_OFFSET + div_quot[36:0]) : (Z_OFFSET - div_quot[36:0]);
            n_q     <= '0;
            red_q   <= RED_TOP;
            state_q <= S_FIN_RED;
          end
        end
        S_FIN_RED: begin
          // Reduce modulo ln 2, one quotient bit per cycle.
          if (z_q >= red_cmp) begin
            z_q           <= z_q - red_cmp;
            n_q[red_q]    <= 1'b1;
          end
          red_q <= red_q - 3'd1;
          if (red_q == 3'd0) begin
            state_q <= S_EXP_MUL;
          end
        end
        S_EXP_MUL: state_q <= S_EXP_DST;
        S_EXP_DST: state_q <= S_EXP_DWAIT;
        S_EXP_DWAIT: begin
          // Taylor term: (term * r) / k, summed as it comes.
          if (div_done) begin
            term_q <= div_quot[32:0];
            sum_q  <= sum_q + {1'b0, div_quot[32:0]};
            k_q    <= k_q + 4'd1;
            state_q <= (k_q == TAYLOR_TERMS) ? S_EXP_FIN : S_EXP_MUL;
          end
        end
        S_EXP_FIN: begin
          // Scale the series by 2^(n-39) with rounding, clamp to 32 bits.
          if (exp_res > 41'h0_FFFF_FFFF) begin
            flag_q  <= 1'b1;
            scale_q <= 32'hFFFF_FFFF;
          end else begin
            scale_q <= exp_res[31:0];
          end
          power_q <= '0;
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_scale_q  <= scale_q;
            out_vel_q[0] <= res_q[0];
            out_vel_q[1] <= res_q[1];
            out_vel_q[2] <= res_q[2];
            out_sat_q    <= flag_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      // Series start values are set when the reduction begins.
      if (state_q == S_FIN_CHK) begin
        term_q <= 33'h1_0000_0000;
        sum_q  <= 34'h1_0000_0000;
        k_q    <= 4'd1;
      end
    end
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign scale_factor_o = out_scale_q;
  assign out_vel_x_o    = out_vel_q[0];
  assign out_vel_y_o    = out_vel_q[1];
  assign out_vel_z_o    = out_vel_q[2];
  assign saturated_o    = out_sat_q;

endmodule

>>> bench/isokinetic_velocity_rescaler_checker.sv
`timescale 1ns / 1ps
// Checker for the isokinetic velocity rescaler: predicts each response and compares it.
module isokinetic_velocity_rescaler_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] vel_x_i,
  input  logic [31:0] vel_y_i,
  input  logic [31:0] vel_z_i,
  input  logic [31:0] force_x_i,
  input  logic [31:0] force_y_i,
  input  logic [31:0] force_z_i,
  input  logic [47:0] kinetic_energy_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [31:0] scale_factor_i,
  input  logic [31:0] out_vel_x_i,
  input  logic [31:0] out_vel_y_i,
  input  logic [31:0] out_vel_z_i,
  input  logic        saturated_i,
  output int          errors_o,
  output int          pending_o
);
  import ivr_pkg::*;

  typedef struct packed {
    logic [31:0] scale;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] vz;
    logic        sat;
  } thermo_resp_t;

  thermo_resp_t     resp_q[$];
  logic [31:0]      half_dt;
  logic signed [63:0] power_acc;
  logic [31:0]      scale_hold;

  // Saturating add into the power accumulator.
  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b,
                                                 inout logic flag);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      flag = 1'b1;
      s = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s;
  endfunction

  // Taylor series of exp(r) for r in [0, ln 2), all in Q.32.
  function automatic logic [63:0] exp_frac(input logic [63:0] r);
    logic [63:0] sum;
    logic [63:0] term;
    sum  = 64'd1 << 32;
    term = 64'd1 << 32;
    for (int k = 1; k <= 14; k++) begin
      term = ((term * r) >> 32) / k;
      sum += term;
    end
    return sum;
  endfunction

  // Scale factor exp(-0.5 * power / (energy + 1) * half_dt) in Q4.28.
  function automatic logic [31:0] derive_scale(input logic signed [63:0] acc,
                                               input logic [47:0] energy,
                                               inout logic flag);
    logic [95:0] prod;
    logic [95:0] dv;
    logic [95:0] quot;
    logic [63:0] mag;
    logic [63:0] q;
    logic signed [63:0] y;
    logic [63:0] z;
    logic [63:0] n;
    logic [63:0] e;
    logic [63:0] s;
    logic [63:0] res;
    mag  = acc[63] ? -acc : acc;
    prod = {32'd0, mag} * {64'd0, half_dt};
    dv   = ({48'd0, energy} + 96'd1) << 9;
    quot = prod / dv;
    q    = (quot > {58'd0, X_CAP}) ? {26'd0, X_CAP} : quot[63:0];
    y    = acc[63] ? $signed(q) : -$signed(q);
    if (y > $signed({26'd0, Y_HIGH})) begin
      flag = 1'b1;
      return 32'hFFFF_FFFF;
    end
    z   = y + $signed({27'd0, Z_OFFSET});
    n   = z / {32'd0, LN2_Q32};
    e   = exp_frac(z - n * {32'd0, LN2_Q32});
    s   = {58'd0, SHIFT_BASE} - n;
    res = (s == 0) ? e : (e + (64'd1 << (s - 1))) >> s;
    if (res > 64'hFFFF_FFFF) begin
      flag = 1'b1;
      return 32'hFFFF_FFFF;
    end
    return res[31:0];
  endfunction

  // One velocity times the held scale, rounded half away from zero.
  function automatic logic [31:0] rescale_comp(input logic [31:0] v, inout logic flag);
    logic signed [63:0] p;
    logic [63:0] m;
    logic [63:0] r;
    p = $signed({{32{v[31]}}, v}) * $signed({32'd0, scale_hold});
    m = p[63] ? -p : p;
    r = (m + (64'd1 << 27)) >> 28;
    if (!p[63] && r > 64'h7FFF_FFFF) begin
      flag = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (p[63] && r > 64'h8000_0000) begin
      flag = 1'b1;
      return 32'h8000_0000;
    end
    return p[63] ? -r[31:0] : r[31:0];
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch in %s: got %h, expected %h at %0t", what, got, want, $time);
    errors_o++;
  endtask

  // Compare accepted responses first, then predict from the accepted request.
  always @(posedge clk_i or negedge rst_ni) begin
    thermo_resp_t exp_r;
    logic flag;
    if (!rst_ni) begin
      half_dt    = HALF_DT_RESET;
      power_acc  = '0;
      scale_hold = SCALE_ONE;
      errors_o   = 0;
      resp_q.delete();
      pending_o  = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (resp_q.size() == 0) begin
          report("response count", 32'd1, 32'd0);
        end else begin
          exp_r = resp_q.pop_front();
          if (scale_factor_i !== exp_r.scale) report("scale", scale_factor_i, exp_r.scale);
          if (out_vel_x_i !== exp_r.vx) report("vel_x", out_vel_x_i, exp_r.vx);
          if (out_vel_y_i !== exp_r.vy) report("vel_y", out_vel_y_i, exp_r.vy);
          if (out_vel_z_i !== exp_r.vz) report("vel_z", out_vel_z_i, exp_r.vz);
          if (saturated_i !== exp_r.sat) report("saturated", saturated_i, exp_r.sat);
        end
      end
      if (cfg_we_i) half_dt = cfg_wdata_i;
      if (in_valid_i && !in_stall_i && ivr_op_e'(opcode_i) != OP_NONE) begin
        flag  = 1'b0;
        exp_r = '0;
        case (ivr_op_e'(opcode_i))
          OP_ACC: begin
            power_acc = sat_add(power_acc,
                                64'($signed(vel_x_i)) * 64'($signed(force_x_i)), flag);
            power_acc = sat_add(power_acc,
                                64'($signed(vel_y_i)) * 64'($signed(force_y_i)), flag);
            power_acc = sat_add(power_acc,
                                64'($signed(vel_z_i)) * 64'($signed(force_z_i)), flag);
          end
          OP_FIN: begin
            scale_hold = derive_scale(power_acc, kinetic_energy_i, flag);
            power_acc  = '0;
          end
          default: begin
            exp_r.vx = rescale_comp(vel_x_i, flag);
            exp_r.vy = rescale_comp(vel_y_i, flag);
            exp_r.vz = rescale_comp(vel_z_i, flag);
          end
        endcase
        exp_r.scale = scale_hold;
        exp_r.sat   = flag;
        resp_q.push_back(exp_r);
      end
      pending_o = resp_q.size();
    end
  end

endmodule

>>> bench/isokinetic_velocity_rescaler_top_test.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the isokinetic velocity rescaler.
module isokinetic_velocity_rescaler_top_test;
  import ivr_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  opcode_i = '0;
  logic [31:0] vel_x_i = '0, vel_y_i = '0, vel_z_i = '0;
  logic [31:0] force_x_i = '0, force_y_i = '0, force_z_i = '0;
  logic [47:0] kinetic_energy_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] scale_factor_o, out_vel_x_o, out_vel_y_o, out_vel_z_o;
  logic        saturated_o;
  int          errors, pending;
  int          sent;
  logic        tx_calm = 1'b0;
  logic        rx_calm = 1'b0;
  int          rx_hold;

  isokinetic_velocity_rescaler_top uut (.*);

  isokinetic_velocity_rescaler_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_i(in_stall_o), .opcode_i,
    .vel_x_i, .vel_y_i, .vel_z_i, .force_x_i, .force_y_i, .force_z_i,
    .kinetic_energy_i, .out_valid_i(out_valid_o), .out_stall_i,
    .scale_factor_i(scale_factor_o), .out_vel_x_i(out_vel_x_o),
    .out_vel_y_i(out_vel_y_o), .out_vel_z_i(out_vel_z_o),
    .saturated_i(saturated_o), .errors_o(errors), .pending_o(pending)
  );

  // Clock.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Response side: stall for a drawn number of cycles after each response.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rx_hold     <= 0;
    end else begin
      if ($urandom_range(0, 299) == 0) rx_calm <= !rx_calm;
      if (out_valid_o && !out_stall_i) begin
        int k;
        k = rx_calm ? 0 : $urandom_range(0, 4);
        rx_hold     <= k;
        out_stall_i <= (k != 0);
      end else if (rx_hold > 0) begin
        rx_hold     <= rx_hold - 1;
        out_stall_i <= (rx_hold > 1);
      end
    end
  end

  // Watchdog.
  initial begin
    #100_000_000;
    $display("isokinetic_velocity_rescaler_top_test NOT OK");
    $finish;
  end

  // Present one request after a drawn gap and wait until it is taken.
  task automatic send(input ivr_op_e op, input logic [31:0] vx, vy, vz, fx, fy, fz,
                      input logic [47:0] ke);
    int gap;
    if ($urandom_range(0, 199) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    opcode_i         <= op;
    vel_x_i          <= vx;
    vel_y_i          <= vy;
    vel_z_i          <= vz;
    force_x_i        <= fx;
    force_y_i        <= fy;
    force_z_i        <= fz;
    kinetic_energy_i <= ke;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent++;
  endtask

  // Wait out every response plus the finish latency, then reprogram the step.
  task automatic program_step(input logic [31:0] value);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (700) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Component values biased toward the extremes and toward small magnitudes.
  function automatic logic [31:0] pick_comp();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2, 3, 4, 5: return $urandom_range(0, 32'h0007_FFFF) - 32'h0004_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [47:0] pick_energy();
    case ($urandom_range(0, 7))
      0: return 48'd0;
      1: return 48'hFFFF_FFFF_FFFF;
      2, 3: return 48'($urandom_range(0, 32'h00FF_FFFF));
      default: return {16'($urandom_range(0, 16'hFFFF)), 32'($urandom)};
    endcase
  endfunction

  task automatic send_atom(input ivr_op_e op);
    send(op, pick_comp(), pick_comp(), pick_comp(), pick_comp(), pick_comp(), pick_comp(),
         pick_energy());
  endtask

  initial begin
    logic [31:0] steps[6];
    steps = '{HALF_DT_RESET, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0100_0000, 32'h0, 32'h0};
    sent  = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: saturating accumulate, extreme energies, negative power, unused opcode.
    program_step(HALF_DT_RESET);
    send(OP_ACC, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
         32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '0);
    send(OP_RSC, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_8000, '0, '0, '0, '0);
    send(OP_FIN, '0, '0, '0, '0, '0, '0, 48'h0);
    send(OP_RSC, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, '0, '0, '0, '0);
    send(OP_ACC, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
         32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '0);
    send(OP_ACC, 32'h7FFF_FFFF, '0, '0, 32'h8000_0000, '0, '0, '0);
    send(OP_FIN, '0, '0, '0, '0, '0, '0, 48'hFFFF_FFFF_FFFF);
    send(OP_ACC, 32'hFFFF_0000, 32'h0001_0000, '0, 32'h0001_0000, 32'hFFFF_0000, '0, '0);
    send(OP_FIN, '0, '0, '0, '0, '0, '0, 48'h0000_0001_0000);
    send(OP_RSC, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, '0, '0, '0, '0);
    send(OP_NONE, 32'h1234_5678, '0, '0, '0, '0, '0, 48'hFFFF_FFFF_FFFF);
    send(OP_ACC, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
         32'h0001_0000, 32'h0001_0000, 32'h0001_0000, '0);
    send(OP_FIN, '0, '0, '0, '0, '0, '0, 48'h0000_0003_0000);
    send(OP_RSC, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001, '0, '0, '0, '0);
    send(OP_FIN, '0, '0, '0, '0, '0, '0, 48'h0);
    send(OP_RSC, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000, '0, '0, '0, '0);

    // Random: accumulate runs, a finish, rescale runs, with some noise.
    steps[4] = $urandom;
    steps[5] = $urandom;
    for (int ph = 0; ph < 6; ph++) begin
      program_step(steps[ph]);
      while (sent < 16 + (ph + 1) * 325) begin
        repeat ($urandom_range(1, 6)) send_atom(OP_ACC);
        if ($urandom_range(0, 9) == 0) send_atom(ivr_op_e'($urandom_range(0, 3)));
        send_atom(OP_FIN);
        repeat ($urandom_range(1, 6)) send_atom(OP_RSC);
        if ($urandom_range(0, 19) == 0) begin
          // Let the block drain completely before going on.
          in_valid_i <= 1'b0;
          @(posedge clk_i);
          while (pending != 0) @(posedge clk_i);
        end
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (700) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("isokinetic_velocity_rescaler_top_test OK");
    end else begin
      $display("isokinetic_velocity_rescaler_top_test NOT OK");
    end
    $finish;
  end

endmodule
